[hw/rtl/light_flicker_animator_defines.svh]
// Assertion macros for the light flicker animator.
// Included by the top level; expects clk and rst_n in scope.
`ifndef LIGHT_FLICKER_ANIMATOR_DEFINES_SVH
`define LIGHT_FLICKER_ANIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfa: implication check failed");
// next-cycle implication
`define LFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfa: next-cycle check failed");
`else
`define LFA_ASSERT_IMP(label, ante, cons)
`define LFA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/lfa_pkg.sv]
// Shared types and constants for the light flicker animator.
// No dependencies; imported by lfa_mul, light_flicker_animator and the testbench.
package lfa_pkg;

  localparam int unsigned LVL_W      = 17;
  localparam int unsigned BASE_W     = 8;
  localparam int unsigned PARAM_W    = 11;
  localparam int unsigned TYPE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COMP_W     = 16;
  localparam int unsigned RAND_W     = 16;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned MAG_W      = 14;
  localparam int unsigned DELTA_W    = 18;
  localparam int unsigned FRAC_W     = 20;

  localparam int unsigned MUL_A_W = 30;
  localparam int unsigned MUL_B_W = 21;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [LVL_W-1:0]   FULL_LEVEL = 17'h10000;
  // ceil(2^24/10): exact floor(n/10) as (n*RECIP10)>>24 for n < 2^22
  localparam logic [MUL_B_W-1:0] RECIP10    = 21'd1677722;
  // ms per s (1000) over 8, the 2^3 lives in the >>24
  localparam logic [MUL_B_W-1:0] HOLD_SCALE = 21'd125;
  localparam logic [PARAM_W-1:0] PARAM_MIN  = 11'd10;
  localparam logic [PARAM_W-1:0] PARAM_MAX  = 11'd1024;

  localparam logic [TYPE_W-1:0] TYPE_STATIC  = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_FIRE    = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_CANDLE  = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_FLICKER = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PARAM = 2'd2;

  localparam logic [PHASE_W-1:0] PH_START = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DOWN  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_UP    = 2'd2;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_DISP  = 12'b0000_0000_0010,
    ST_TQ    = 12'b0000_0000_0100,
    ST_TDIV  = 12'b0000_0000_1000,
    ST_TFB   = 12'b0000_0001_0000,
    ST_SQ    = 12'b0000_0010_0000,
    ST_SDIV  = 12'b0000_0100_0000,
    ST_SDIV2 = 12'b0000_1000_0000,
    ST_DELTA = 12'b0001_0000_0000,
    ST_HOLD1 = 12'b0010_0000_0000,
    ST_HOLD2 = 12'b0100_0000_0000,
    ST_OUT   = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_FIRST = 2'd1,
    EV_UP    = 2'd2,
    EV_DOWN  = 2'd3
  } ramp_ev_t;

endpackage

[hw/rtl/lfa_mul.sv]
// Shared registered multiplier for the light flicker animator.
// Depends on lfa_pkg (mul_req_t, operand widths).
module lfa_mul (
  input  logic                            clk,
  input  lfa_pkg::mul_req_t               req,
  output logic [lfa_pkg::MUL_P_W-1:0]     prod
);
  import lfa_pkg::*;

  logic [MUL_P_W-1:0] prod_r;
  logic [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = MUL_P_W'(req.a) * MUL_P_W'(req.b);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

[hw/rtl/light_flicker_animator.sv]
// Light flicker animator: one result item per input item (tick).
// A tick runs ST_DISP to ST_OUT: static, fade, idle flicker directly, a flicker
// toggle via ST_HOLD1/2, fire/candle via multiply states (most for a new target).
// in_stall is high until ST_OUT is left, and ST_OUT waits out a stalled result.
// Reset: rst_n synchronous active low; registers to type 0, base 255, param 512,
// level full, phase/target/step/next time zero.
`include "light_flicker_animator_defines.svh"

module light_flicker_animator (
  input  logic                               clk,
  input  logic                               rst_n,
  // tick input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lfa_pkg::TIME_W-1:0]         in_time_ms,
  input  logic [lfa_pkg::COMP_W-1:0]         in_frame_comp,
  input  logic [lfa_pkg::RAND_W-1:0]         in_rand_a,
  input  logic [lfa_pkg::RAND_W-1:0]         in_rand_b,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lfa_pkg::LVL_W-1:0]          out_level,
  output logic [lfa_pkg::ALPHA_W-1:0]        out_alpha,
  output logic [lfa_pkg::PHASE_W-1:0]        out_phase,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lfa_pkg::*;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  // configuration
  logic [TYPE_W-1:0]  type_r,  type_nxt;
  logic [BASE_W-1:0]  base_r,  base_nxt;
  logic [PARAM_W-1:0] param_r, param_nxt;

  // sequencer
  state_t   state_r, state_nxt;
  ramp_ev_t ev_r,    ev_nxt;

  // latched tick payload
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [COMP_W-1:0] comp_r, comp_nxt;
  logic [RAND_W-1:0] ra_r,   ra_nxt;
  logic [RAND_W-1:0] rb_r,   rb_nxt;

  // animation state; the signed step is kept as sign + magnitude
  logic [PHASE_W-1:0] phase_r,    phase_nxt;
  logic [LVL_W-1:0]   level_r,    level_nxt;
  logic [LVL_W-1:0]   target_r,   target_nxt;
  logic               step_neg_r, step_neg_nxt;
  logic [MAG_W-1:0]   step_mag_r, step_mag_nxt;
  logic [TIME_W-1:0]  next_ms_r,  next_ms_nxt;

  // output register, parts the sequencer from the result channel
  logic               out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0]   out_level_r, out_level_nxt;
  logic [ALPHA_W-1:0] out_alpha_r, out_alpha_nxt;
  logic [PHASE_W-1:0] out_phase_r, out_phase_nxt;

  // ---------------------------------------------------------------------------
  // Shared multiplier: operands issued in one state, product used in the next
  // ---------------------------------------------------------------------------
  mul_req_t           mul_req;
  logic [MUL_P_W-1:0] prod;

  lfa_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // ---------------------------------------------------------------------------
  // Helper terms
  // ---------------------------------------------------------------------------
  logic               is_candle;
  logic [LVL_W-1:0]   base_lvl;     // floor(base*65536/255)
  logic [PARAM_W-1:0] param_c;      // type_param clamped to 10..1024
  logic [FRAC_W-1:0]  f_down;       // lo*65536 + span*rand_a, target fractions in tenths
  logic [FRAC_W-1:0]  f_up;
  logic [FRAC_W-1:0]  f_hold_on;    // 65536 + 7*rand_a
  logic [FRAC_W-1:0]  f_hold_off;   // 65536 + 3*rand_a
  logic [FRAC_W-1:0]  fb_base;      // B or 8B, divided by ten on a dimming fallback
  logic [TIME_W-1:0]  time_diff;
  logic               expired;
  ramp_ev_t           ramp_ev;
  logic [LVL_W-1:0]   div_tgt;      // quotient slice of a divide-by-ten pass
  logic [MAG_W-1:0]   div_mag;
  logic [DELTA_W-1:0] delta;
  logic [LVL_W+1:0]   lvl_sum;
  logic [LVL_W+7:0]   lvl_x255;
  logic [ALPHA_W-1:0] alpha_c;
  mul_req_t           req_step;

  // 65536/255 = 257 + 1/255, so B = base*257 except full scale at 255
  assign base_lvl  = (base_r == {BASE_W{1'b1}}) ? FULL_LEVEL : {1'b0, base_r, base_r};
  assign param_c   = (param_r < PARAM_MIN) ? PARAM_MIN :
                     (param_r > PARAM_MAX) ? PARAM_MAX : param_r;
  assign is_candle = (type_r == TYPE_CANDLE);

  assign f_down = is_candle ? ({4'd8, 16'd0} + FRAC_W'(ra_r))
                            : ({4'd4, 16'd0} + FRAC_W'({ra_r, 2'b00}) + FRAC_W'(ra_r));
  assign f_up   = is_candle ? ({4'd9, 16'd0} + FRAC_W'(ra_r))
                            : ({4'd8, 16'd0} + FRAC_W'({ra_r, 1'b0}));
  assign f_hold_on  = FRAC_W'(FULL_LEVEL) + FRAC_W'({ra_r, 3'b000}) - FRAC_W'(ra_r);
  assign f_hold_off = FRAC_W'(FULL_LEVEL) + FRAC_W'({ra_r, 1'b0}) + FRAC_W'(ra_r);
  assign fb_base    = is_candle ? FRAC_W'({base_lvl, 3'b000}) : FRAC_W'(base_lvl);

  // serial-order compare: later when the wrapped difference is in 1..2^31-1
  assign time_diff = time_r - next_ms_r;
  assign expired   = (time_diff != '0) && !time_diff[TIME_W-1];

  always_comb begin
    case (phase_r)
      PH_START: ramp_ev = EV_FIRST;
      PH_DOWN:  ramp_ev = (level_r <= target_r) ? EV_UP : EV_NONE;
      PH_UP:    ramp_ev = (level_r >= target_r) ? EV_DOWN : EV_NONE;
      default:  ramp_ev = EV_NONE;
    endcase
  end

  assign div_tgt = prod[24 +: LVL_W];
  assign div_mag = prod[24 +: MAG_W];
  assign delta   = prod[12 +: DELTA_W];
  assign lvl_sum = (LVL_W+2)'(level_r) + (LVL_W+2)'(delta);

  // alpha = floor(level*255/65536)
  assign lvl_x255 = {level_r, 8'b0} - (LVL_W+8)'(level_r);
  assign alpha_c  = lvl_x255[16 +: ALPHA_W];

  // step draw: P*(65536+rand_b), then >>10 and one or two divide-by-ten passes
  assign req_step = '{en: 1'b1, a: MUL_A_W'({1'b1, rb_r}), b: MUL_B_W'(param_c)};

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    type_nxt      = type_r;
    base_nxt      = base_r;
    param_nxt     = param_r;
    state_nxt     = state_r;
    ev_nxt        = ev_r;
    time_nxt      = time_r;
    comp_nxt      = comp_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    phase_nxt     = phase_r;
    level_nxt     = level_r;
    target_nxt    = target_r;
    step_neg_nxt  = step_neg_r;
    step_mag_nxt  = step_mag_r;
    next_ms_nxt   = next_ms_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_level_nxt = out_level_r;
    out_alpha_nxt = out_alpha_r;
    out_phase_nxt = out_phase_r;
    mul_req       = '0;

    // config writes must land only while idle (user's rule, not enforced by the block)
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_TYPE:  type_nxt  = cfg_data[TYPE_W-1:0];
        CFG_IDX_BASE:  base_nxt  = cfg_data[BASE_W-1:0];
        CFG_IDX_PARAM: param_nxt = cfg_data[PARAM_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          time_nxt  = in_time_ms;
          comp_nxt  = in_frame_comp;
          ra_nxt    = in_rand_a;
          rb_nxt    = in_rand_b;
          state_nxt = ST_DISP;
        end
      end

      ST_DISP: begin
        case (type_r)
          TYPE_STATIC: begin
            level_nxt = base_lvl;
            state_nxt = ST_OUT;
          end
          TYPE_FIRE, TYPE_CANDLE: begin
            ev_nxt = ramp_ev;
            case (ramp_ev)
              EV_FIRST, EV_DOWN: begin
                phase_nxt = PH_DOWN;
                mul_req   = '{en: 1'b1, a: MUL_A_W'(f_down), b: MUL_B_W'(base_lvl)};
                state_nxt = ST_TQ;
              end
              EV_UP: begin
                phase_nxt = PH_UP;
                mul_req   = '{en: 1'b1, a: MUL_A_W'(f_up), b: MUL_B_W'(base_lvl)};
                state_nxt = ST_TQ;
              end
              default: begin
                // keep ramping with the current step
                mul_req   = '{en: 1'b1, a: MUL_A_W'(comp_r), b: MUL_B_W'(step_mag_r)};
                state_nxt = ST_DELTA;
              end
            endcase
          end
          TYPE_FLICKER: begin
            if (phase_r == PH_START || (phase_r == PH_UP && expired)) begin
              level_nxt = base_lvl;
              phase_nxt = PH_DOWN;
              mul_req   = '{en: 1'b1, a: MUL_A_W'(f_hold_on), b: MUL_B_W'(param_c)};
              state_nxt = ST_HOLD1;
            end else if (phase_r == PH_DOWN && expired) begin
              level_nxt = '0;
              phase_nxt = PH_UP;
              mul_req   = '{en: 1'b1, a: MUL_A_W'(f_hold_off), b: MUL_B_W'(param_c)};
              state_nxt = ST_HOLD1;
            end else begin
              state_nxt = ST_OUT;
            end
          end
          default: state_nxt = ST_OUT;   // fade and unused codes hold
        endcase
      end

      // target = floor(floor(B*f/65536)/10)
      ST_TQ: begin
        mul_req   = '{en: 1'b1, a: MUL_A_W'(prod[16 +: 21]), b: RECIP10};
        state_nxt = ST_TDIV;
      end

      ST_TDIV: begin
        target_nxt = div_tgt;
        if (ev_r == EV_UP && div_tgt <= level_r) begin
          target_nxt = FULL_LEVEL;
        end
        if (ev_r == EV_DOWN && div_tgt >= level_r) begin
          // dimming fallback: B/10 (fire) or 8B/10 (candle)
          mul_req   = '{en: 1'b1, a: MUL_A_W'(fb_base), b: RECIP10};
          state_nxt = ST_TFB;
        end else begin
          mul_req   = req_step;
          state_nxt = ST_SQ;
        end
      end

      ST_TFB: begin
        target_nxt = div_tgt;
        mul_req    = req_step;
        state_nxt  = ST_SQ;
      end

      ST_SQ: begin
        mul_req   = '{en: 1'b1, a: MUL_A_W'(prod[10 +: LVL_W]), b: RECIP10};
        state_nxt = ST_SDIV;
      end

      ST_SDIV: begin
        if (is_candle) begin
          mul_req   = '{en: 1'b1, a: MUL_A_W'(prod[24 +: LVL_W]), b: RECIP10};
          state_nxt = ST_SDIV2;
        end else begin
          step_mag_nxt = div_mag;
          step_neg_nxt = (ev_r != EV_UP);
          mul_req      = '{en: 1'b1, a: MUL_A_W'(comp_r), b: MUL_B_W'(div_mag)};
          state_nxt    = ST_DELTA;
        end
      end

      ST_SDIV2: begin
        step_mag_nxt = div_mag;
        step_neg_nxt = (ev_r != EV_UP);
        mul_req      = '{en: 1'b1, a: MUL_A_W'(comp_r), b: MUL_B_W'(div_mag)};
        state_nxt    = ST_DELTA;
      end

      // level += sign * (|step|*comp >> 12), clamped to 0..full
      ST_DELTA: begin
        if (step_neg_r) begin
          level_nxt = (delta >= DELTA_W'(level_r)) ? '0 : level_r - LVL_W'(delta);
        end else begin
          level_nxt = (lvl_sum > (LVL_W+2)'(FULL_LEVEL)) ? FULL_LEVEL : lvl_sum[LVL_W-1:0];
        end
        state_nxt = ST_OUT;
      end

      // hold ms = P*f*125 >> 24
      ST_HOLD1: begin
        mul_req   = '{en: 1'b1, a: prod[MUL_A_W-1:0], b: HOLD_SCALE};
        state_nxt = ST_HOLD2;
      end

      ST_HOLD2: begin
        next_ms_nxt = time_r + TIME_W'(prod[24 +: 13]);
        state_nxt   = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_r;
          out_alpha_nxt = alpha_c;
          out_phase_nxt = phase_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flops
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r      <= TYPE_STATIC;
      base_r      <= 8'd255;
      param_r     <= 11'd512;
      state_r     <= ST_IDLE;
      ev_r        <= EV_NONE;
      phase_r     <= PH_START;
      level_r     <= FULL_LEVEL;
      target_r    <= '0;
      step_neg_r  <= 1'b0;
      step_mag_r  <= '0;
      next_ms_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      type_r      <= type_nxt;
      base_r      <= base_nxt;
      param_r     <= param_nxt;
      state_r     <= state_nxt;
      ev_r        <= ev_nxt;
      phase_r     <= phase_nxt;
      level_r     <= level_nxt;
      target_r    <= target_nxt;
      step_neg_r  <= step_neg_nxt;
      step_mag_r  <= step_mag_nxt;
      next_ms_r   <= next_ms_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    time_r      <= time_nxt;
    comp_r      <= comp_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    out_level_r <= out_level_nxt;
    out_alpha_r <= out_alpha_nxt;
    out_phase_r <= out_phase_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_alpha = out_alpha_r;
  assign out_phase = out_phase_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LFA_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall, state_r == ST_DISP)
  `LFA_ASSERT_IMP(a_result_from_seq, $rose(out_valid), $past(state_r) == ST_OUT)
  `LFA_ASSERT_IMP(a_result_range, out_valid, out_level <= FULL_LEVEL && out_phase <= PH_UP)
  `LFA_ASSERT_IMP(a_up_step_sign, state_r == ST_DELTA && ev_r == EV_UP, !step_neg_r)

endmodule

[dv/tb_light_flicker_animator.sv]
// Self-checking testbench for light_flicker_animator: directed table, then random phases.
// Depends on lfa_pkg (widths, type codes, config indexes, phase codes) and the RTL top.
// Results are compared to an in-bench model of the animator's state, or to a typed row.
module tb_light_flicker_animator;
  import lfa_pkg::*;

  // Type codes the package does not name: fade holds state, and 5..7 behave like fade.
  localparam logic [TYPE_W-1:0]    TYPE_FADE    = 3'd4;
  localparam logic [TYPE_W-1:0]    TYPE_SPARE   = 3'd7;
  // Fourth config index has no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;

  localparam int DIRECTED_ROWS = 34;
  localparam int RANDOM_TICKS  = 1800;
  // Slowest legal gap between handshakes: an idle gap, a tick's run, then a result stall.
  localparam int QUIET_LIMIT   = 2000;
  localparam int TAIL_CYCLES   = 12;

  typedef struct packed {
    logic [LVL_W-1:0]   level;
    logic [ALPHA_W-1:0] alpha;
    logic [PHASE_W-1:0] phase;
  } lamp_out_t;

  typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;

  // One row of the directed table: either a register write or a tick item.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [TIME_W-1:0]      t;
    logic [COMP_W-1:0]      comp;
    logic [RAND_W-1:0]      ra;
    logic [RAND_W-1:0]      rb;
    bit                     typed;   // known holds the expected item, no prediction
    lamp_out_t              known;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [TIME_W-1:0]     in_time_ms;
  logic [COMP_W-1:0]     in_frame_comp;
  logic [RAND_W-1:0]     in_rand_a;
  logic [RAND_W-1:0]     in_rand_b;
  logic                  out_valid;
  logic                  out_stall;
  logic [LVL_W-1:0]      out_level;
  logic [ALPHA_W-1:0]    out_alpha;
  logic [PHASE_W-1:0]    out_phase;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  light_flicker_animator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_time_ms    (in_time_ms),
    .in_frame_comp (in_frame_comp),
    .in_rand_a     (in_rand_a),
    .in_rand_b     (in_rand_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_level     (out_level),
    .out_alpha     (out_alpha),
    .out_phase     (out_phase),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Animator model: register mirror plus the shared animation state.
  // All arithmetic is done in 64-bit so nothing truncates before the final floor.
  // ---------------------------------------------------------------------------
  logic [TYPE_W-1:0]  lamp_type  = TYPE_STATIC;
  logic [BASE_W-1:0]  lamp_base  = 8'd255;
  logic [PARAM_W-1:0] lamp_param = 11'd512;
  logic [PHASE_W-1:0] lamp_phase = PH_START;
  longint             lamp_level = 65536;
  longint             lamp_target = 0;
  longint             lamp_step = 0;       // signed, negative while dimming
  logic [TIME_W-1:0]  lamp_next_ms = '0;

  lamp_out_t pending_lamp_outs[$];

  int  fail_count   = 0;
  int  ticks_sent   = 0;
  int  results_seen = 0;
  int  cfg_writes   = 0;
  int  flicker_flips = 0;
  bit  in_idle_on   = 1'b1;
  bit  rx_idle_on   = 1'b1;
  int  quiet_cycles = 0;

  // base_intensity as a Q1.16 level
  function automatic longint base_q16();
    longint b;
    b = lamp_base;
    return (b * 65536) / 255;
  endfunction

  // type_param is clamped only where it is used; the register keeps the raw value
  function automatic longint param_q10();
    if (lamp_param < PARAM_MIN) return PARAM_MIN;
    if (lamp_param > PARAM_MAX) return PARAM_MAX;
    return lamp_param;
  endfunction

  // b * randf(lo/10, (lo+span)/10), floor taken once at the end
  function automatic longint ramp_target(longint b, longint lo, longint span, longint r);
    return (b * (lo * 65536 + span * r)) / 655360;
  endfunction

  function automatic longint ramp_step(bit candle, bit up, longint r);
    longint mag;
    mag = (param_q10() * (65536 + r)) / (candle ? 102400 : 10240);
    return up ? mag : -mag;
  endfunction

  // hold time in ms: P * randf(0.5, 0.5*(1+mult)) seconds
  function automatic longint flicker_hold(longint mult, longint r);
    return (param_q10() * (65536 + mult * r) * 125) >>> 24;
  endfunction

  // serial-number compare: now is strictly later than the scheduled change
  function automatic bit hold_expired(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    d = now - lamp_next_ms;
    return (d != '0) && (d < 32'h8000_0000);
  endfunction

  function automatic void ramp_lamp(bit candle, longint comp, longint ra, longint rb);
    longint b;
    longint mag;
    longint lv;
    b = base_q16();
    if (lamp_phase == PH_START) begin
      // first ramp tick: no fallback on the target
      lamp_phase  = PH_DOWN;
      lamp_target = ramp_target(b, candle ? 8 : 4, candle ? 1 : 5, ra);
      lamp_step   = ramp_step(candle, 1'b0, rb);
    end else if (lamp_phase == PH_DOWN && lamp_level <= lamp_target) begin
      lamp_phase  = PH_UP;
      lamp_target = ramp_target(b, candle ? 9 : 8, candle ? 1 : 2, ra);
      if (lamp_target <= lamp_level) lamp_target = 65536;
      lamp_step   = ramp_step(candle, 1'b1, rb);
    end else if (lamp_phase == PH_UP && lamp_level >= lamp_target) begin
      lamp_phase  = PH_DOWN;
      lamp_target = ramp_target(b, candle ? 8 : 4, candle ? 1 : 5, ra);
      if (lamp_target >= lamp_level) lamp_target = candle ? (b * 8) / 10 : b / 10;
      lamp_step   = ramp_step(candle, 1'b0, rb);
    end
    // step is scaled by frame compensation (Q4.12), then the level saturates
    mag = (lamp_step < 0) ? -lamp_step : lamp_step;
    lv  = lamp_level + ((lamp_step < 0) ? -((mag * comp) >>> 12) : ((mag * comp) >>> 12));
    if (lv < 0) lv = 0;
    if (lv > 65536) lv = 65536;
    lamp_level = lv;
  endfunction

  function automatic void flicker_lamp(logic [TIME_W-1:0] now, longint ra);
    if (lamp_phase == PH_START) begin
      lamp_level   = base_q16();
      lamp_next_ms = now + TIME_W'(flicker_hold(7, ra));
      lamp_phase   = PH_DOWN;
    end else if (lamp_phase == PH_DOWN && hold_expired(now)) begin
      lamp_level   = 0;
      lamp_next_ms = now + TIME_W'(flicker_hold(3, ra));
      lamp_phase   = PH_UP;
      flicker_flips++;
    end else if (lamp_phase == PH_UP && hold_expired(now)) begin
      lamp_level   = base_q16();
      lamp_next_ms = now + TIME_W'(flicker_hold(7, ra));
      lamp_phase   = PH_DOWN;
      flicker_flips++;
    end
  endfunction

  // Advance the model by one tick and return the item the block should emit.
  function automatic lamp_out_t step_lamp(logic [TIME_W-1:0] t, logic [COMP_W-1:0] comp,
                                          logic [RAND_W-1:0] ra, logic [RAND_W-1:0] rb);
    lamp_out_t o;
    longint    a;
    case (lamp_type)
      TYPE_STATIC:  lamp_level = base_q16();   // phase is left alone
      TYPE_FIRE:    ramp_lamp(1'b0, comp, ra, rb);
      TYPE_CANDLE:  ramp_lamp(1'b1, comp, ra, rb);
      TYPE_FLICKER: flicker_lamp(t, ra);
      default: ;                                // fade and spare codes hold everything
    endcase
    a       = (lamp_level * 255) >>> 16;
    o.level = LVL_W'(lamp_level);
    o.alpha = ALPHA_W'(a);
    o.phase = lamp_phase;
    return o;
  endfunction

  function automatic void mirror_lamp_reg(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IDX_TYPE:  lamp_type  = data[TYPE_W-1:0];
      CFG_IDX_BASE:  lamp_base  = data[BASE_W-1:0];
      CFG_IDX_PARAM: lamp_param = data[PARAM_W-1:0];
      default: ;                                // unmapped index: ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t tick_row(logic [TIME_W-1:0] t, logic [COMP_W-1:0] comp,
                                         logic [RAND_W-1:0] ra, logic [RAND_W-1:0] rb);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_TICK;
    r.t    = t;
    r.comp = comp;
    r.ra   = ra;
    r.rb   = rb;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [TIME_W-1:0] t, logic [COMP_W-1:0] comp,
                                          logic [RAND_W-1:0] ra, logic [RAND_W-1:0] rb,
                                          logic [LVL_W-1:0] level, logic [ALPHA_W-1:0] alpha,
                                          logic [PHASE_W-1:0] phase);
    stim_row_t r;
    r             = tick_row(t, comp, ra, rb);
    r.typed       = 1'b1;
    r.known.level = level;
    r.known.alpha = alpha;
    r.known.phase = phase;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Valid is left high after an accept; it is only dropped when a gap or a settle follows,
  // so back-to-back items never see a low/high pair in one time step.
  task automatic send_tick(input logic [TIME_W-1:0] t, input logic [COMP_W-1:0] comp,
                           input logic [RAND_W-1:0] ra, input logic [RAND_W-1:0] rb,
                           input bit typed, input lamp_out_t known);
    int unsigned gap;
    lamp_out_t   predicted;
    gap = in_idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_time_ms    <= t;
    in_frame_comp <= comp;
    in_rand_a     <= ra;
    in_rand_b     <= rb;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = step_lamp(t, comp, ra, rb);
    pending_lamp_outs.push_back(typed ? known : predicted);
    ticks_sent++;
  endtask

  // Block is idle once every outstanding tick has produced its item
  // (every tick yields exactly one, so an empty queue means nothing in flight).
  task automatic settle_lamp();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_lamp_outs.size() != 0);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle_lamp();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    mirror_lamp_reg(idx, data);
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Ends the run if no channel completes a handshake while quiet_cycles reaches QUIET_LIMIT.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall) || (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d items outstanding",
               QUIET_LIMIT, pending_lamp_outs.size());
      $display("tb_light_flicker_animator failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall per item, then compare against the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    lamp_out_t   got;
    lamp_out_t   want;
    out_stall = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      hold = rx_idle_on ? $urandom_range(0, 15) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.level = out_level;
      got.alpha = out_alpha;
      got.phase = out_phase;
      results_seen++;
      if (pending_lamp_outs.size() == 0) begin
        $error("unexpected item: level=%0d alpha=%0d phase=%0d",
               got.level, got.alpha, got.phase);
        fail_count++;
      end else begin
        want = pending_lamp_outs.pop_front();
        if (got.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, got.level);
          fail_count++;
        end
        if (got.alpha !== want.alpha) begin
          $error("alpha: expected %0d, got %0d", want.alpha, got.alpha);
          fail_count++;
        end
        if (got.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, got.phase);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t         directed_rows [DIRECTED_ROWS];
    stim_row_t         row;
    int                directed_ticks;
    int                random_ticks;
    int unsigned       n;
    int unsigned       step_max;
    bit                wild_comp;
    logic [TYPE_W-1:0] kind;
    logic [BASE_W-1:0] base;
    logic [PARAM_W-1:0] param;
    logic [TIME_W-1:0] clock_ms;
    logic [COMP_W-1:0] comp;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_time_ms    = '0;
    in_frame_comp = '0;
    in_rand_a     = '0;
    in_rand_b     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_IDX_TYPE;
    cfg_data      = '0;

    // Directed part. Rows with typed results: reset state at full base, and base 0.
    directed_rows = '{
      // static right after reset: full level, phase untouched
      known_row(32'd0, 16'd0, 16'd0, 16'd0, FULL_LEVEL, 8'd255, PH_START),
      cfg_row(CFG_IDX_BASE, 11'd0),
      known_row('1, '1, '1, '1, 17'd0, 8'd0, PH_START),
      cfg_row(CFG_IDX_BASE, 11'h7FF),            // upper data bits must be masked
      cfg_row(CFG_IDX_PARAM, 11'h7FF),           // above range, clamps to 1024
      cfg_row(CFG_IDX_TYPE, TYPE_FIRE),
      tick_row(32'd0, 16'd4096, 16'd0, 16'd0),   // start phase: first down target
      tick_row(32'd16, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      tick_row(32'd32, 16'hFFFF, 16'd0, 16'hFFFF),
      tick_row(32'd48, 16'hFFFF, 16'hFFFF, 16'd0),
      tick_row(32'd64, 16'hFFFF, 16'h8000, 16'h8000),
      tick_row(32'd80, 16'd0, 16'h1234, 16'hFFFF), // zero compensation: level frozen
      cfg_row(CFG_IDX_PARAM, 11'd0),             // below range, clamps to 10
      cfg_row(CFG_IDX_TYPE, TYPE_CANDLE),
      tick_row(32'd96, 16'd4096, 16'h8000, 16'd0),
      tick_row(32'd112, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      cfg_row(CFG_IDX_PARAM, 11'd10),
      cfg_row(CFG_IDX_TYPE, TYPE_FLICKER),
      tick_row(32'hFFFF_FF00, 16'd4096, 16'hFFFF, 16'd0), // behind the change time
      tick_row(32'd0, 16'd4096, 16'hFFFF, 16'd0),          // exactly at it: not yet
      tick_row(32'd1, 16'd4096, 16'd0, 16'd0),             // one past: flips
      tick_row(32'd1, 16'd4096, 16'hFFFF, 16'hFFFF),
      tick_row(32'h8000_0000, 16'd4096, 16'h00FF, 16'd0),  // far ahead, across half range
      tick_row(32'hFFFF_FFFF, 16'd4096, 16'hFF00, 16'd0),
      cfg_row(CFG_IDX_TYPE, TYPE_FADE),
      tick_row(32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      cfg_row(CFG_IDX_TYPE, TYPE_SPARE),         // unused code behaves as a hold
      tick_row(32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0),
      cfg_row(CFG_IDX_NONE, 11'h7FF),            // no register there: no effect
      tick_row(32'd5, 16'd4096, 16'h5555, 16'hAAAA),
      cfg_row(CFG_IDX_TYPE, TYPE_STATIC),
      cfg_row(CFG_IDX_BASE, 11'd1),
      tick_row(32'd6, 16'd4096, 16'hAAAA, 16'h5555),
      cfg_row(CFG_IDX_PARAM, 11'd512)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        program_reg(row.idx, row.data);
      end else begin
        send_tick(row.t, row.comp, row.ra, row.rb, row.typed, row.known);
      end
    end
    directed_ticks = ticks_sent;

    // Random part: each phase picks a register setting, then streams ticks with
    // a monotonic clock (so flicker holds actually expire) plus rare time jumps.
    random_ticks = 0;
    clock_ms     = 32'd1000;
    while (random_ticks < RANDOM_TICKS) begin
      case ($urandom_range(0, 11))
        0:          kind = TYPE_STATIC;
        1, 2, 3:    kind = TYPE_FIRE;
        4, 5, 6:    kind = TYPE_CANDLE;
        7, 8, 9:    kind = TYPE_FLICKER;
        10:         kind = TYPE_FADE;
        default:    kind = TYPE_FADE + TYPE_W'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 3))
        0:       base = 8'd0;
        1:       base = 8'd255;
        default: base = 8'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       param = 11'($urandom_range(0, 9));
        1:       param = PARAM_MIN;
        2:       param = PARAM_MAX;
        3:       param = 11'($urandom_range(1025, 2047));
        default: param = 11'($urandom_range(10, 1024));
      endcase

      // garbage in the unused upper data bits must not leak into the registers
      program_reg(CFG_IDX_TYPE, {8'($urandom), kind});
      program_reg(CFG_IDX_BASE, {3'($urandom), base});
      program_reg(CFG_IDX_PARAM, param);
      if ($urandom_range(0, 3) == 0) program_reg(CFG_IDX_NONE, 11'($urandom));

      // handshake pressure: most phases idle both sides, some run flat out
      in_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      wild_comp  = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       step_max = 20;
        1:       step_max = 400;
        default: step_max = 3000;
      endcase
      if ($urandom_range(0, 3) == 0)
        clock_ms = $urandom_range(0, 1) ? 32'hFFFF_F000 : 32'($urandom);

      n = $urandom_range(20, 120);
      repeat (n) begin
        if ($urandom_range(0, 49) == 0) clock_ms = 32'($urandom);
        else clock_ms = clock_ms + 32'($urandom_range(0, step_max));
        comp = wild_comp ? 16'($urandom) : 16'($urandom_range(2048, 8192));
        send_tick(clock_ms, comp, 16'($urandom), 16'($urandom), 1'b0, '0);
        random_ticks++;
      end
    end

    // Drain, then idle for a tail so the block can show any stray item.
    settle_lamp();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_lamp_outs.size() != 0) begin
      $error("%0d expected items never arrived", pending_lamp_outs.size());
      fail_count++;
    end

    $display("ran %0d ticks (%0d from the table) with %0d register writes",
             ticks_sent, directed_ticks, cfg_writes);
    $display("checked %0d items, saw %0d flicker on/off switches, %0d mismatches",
             results_seen, flicker_flips, fail_count);
    if (fail_count == 0) begin
      $display("tb_light_flicker_animator passed");
    end else begin
      $display("tb_light_flicker_animator failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lfa_pkg.sv
hw/rtl/lfa_mul.sv
hw/rtl/light_flicker_animator.sv
dv/tb_light_flicker_animator.sv
